>>> src/pts_pkg.sv
// Shared types and constants for the priority task scheduler.
package pts_pkg;

    localparam int NUM_PRIOS   = 32;
    localparam int NUM_THREADS = NUM_PRIOS - 1;
    localparam int PRIO_W      = 5;
    localparam int TICKS_W     = 32;
    localparam int OP_W        = 2;
    localparam int IDX_W       = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int WALK_W      = $clog2(NUM_THREADS + 1);

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_DELAY = 2'd1,
        OP_TICK  = 2'd2,
        OP_SCHED = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic tick_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    walk_done;
    } t_dp_stat;

endpackage

>>> src/pts_ctrl.sv
// Controller state machine sequencing one scheduler command at a time.
module pts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pts_pkg::t_dp_stat i_stat,
    output pts_pkg::t_dp_cmd  o_cmd
);

    pts_pkg::t_state r_state;
    pts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pts_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = pts_pkg::ST_EXEC;
                end
            end
            pts_pkg::ST_EXEC: begin
                if (i_stat.op == pts_pkg::OP_TICK) begin
                    n_state = pts_pkg::ST_TICK;
                end else begin
                    n_state = pts_pkg::ST_RESULT;
                end
            end
            pts_pkg::ST_TICK: begin
                if (i_stat.walk_done) begin
                    n_state = pts_pkg::ST_RESULT;
                end
            end
            pts_pkg::ST_RESULT: begin
                n_state = pts_pkg::ST_IDLE;
            end
            default: begin
                n_state = pts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            pts_pkg::ST_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            pts_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            pts_pkg::ST_TICK: begin
                o_cmd.tick_step = 1'b1;
            end
            pts_pkg::ST_RESULT: begin
                o_cmd.finish = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

>>> src/pts_dp.sv
// Datapath: ready and delayed masks, timeout memory, walk counter, result word.
module pts_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pts_pkg::t_dp_cmd             i_cmd,
    output pts_pkg::t_dp_stat            o_stat,
    input  logic [pts_pkg::OP_W-1:0]     i_opcode,
    input  logic [pts_pkg::PRIO_W-1:0]   i_thread_prio,
    input  logic [pts_pkg::TICKS_W-1:0]  i_delay_ticks,
    output logic [pts_pkg::PRIO_W-1:0]   o_next_prio,
    output logic                         o_switch_request,
    output logic                         o_error,
    output logic                         o_valid
);

    logic [pts_pkg::TICKS_W-1:0]     r_mem [pts_pkg::NUM_THREADS];
    logic [pts_pkg::NUM_THREADS-1:0] r_ready;
    logic [pts_pkg::NUM_THREADS-1:0] n_ready;
    logic [pts_pkg::NUM_THREADS-1:0] r_delayed;
    logic [pts_pkg::NUM_THREADS-1:0] n_delayed;
    logic [pts_pkg::PRIO_W-1:0]      r_cur_prio;
    logic                            r_cur_valid;
    pts_pkg::t_opcode                r_op;
    logic [pts_pkg::PRIO_W-1:0]      r_prio;
    logic [pts_pkg::TICKS_W-1:0]     r_ticks;
    logic                            r_sched;
    logic                            n_sched;
    logic                            r_err;
    logic                            n_err;
    logic [pts_pkg::WALK_W-1:0]      r_walk;
    logic                            r_rd_vld;
    logic [pts_pkg::IDX_W-1:0]       r_rd_idx;
    logic [pts_pkg::TICKS_W-1:0]     r_rdata;
    logic [pts_pkg::PRIO_W-1:0]      r_out_prio;
    logic                            r_out_switch;
    logic                            r_out_error;
    logic                            r_out_valid;

    logic                            mem_we;
    logic [pts_pkg::IDX_W-1:0]       mem_waddr;
    logic [pts_pkg::TICKS_W-1:0]     mem_wdata;
    logic [pts_pkg::TICKS_W-1:0]     dec;
    logic [pts_pkg::PRIO_W-1:0]      hr;
    logic [pts_pkg::IDX_W-1:0]       start_idx;
    logic [pts_pkg::IDX_W-1:0]       cur_idx;
    logic                            start_ok;
    logic                            delay_bad;
    logic                            walk_more;
    logic                            sw;

    assign start_idx = pts_pkg::IDX_W'(r_prio - pts_pkg::PRIO_W'(1));
    assign cur_idx   = pts_pkg::IDX_W'(r_cur_prio - pts_pkg::PRIO_W'(1));
    assign start_ok  = (r_prio != '0) && (32'(r_prio) < 32'(pts_pkg::NUM_PRIOS));
    assign delay_bad = !r_cur_valid || (r_cur_prio == '0) || (r_ticks == '0);
    assign walk_more = r_walk < pts_pkg::WALK_W'(pts_pkg::NUM_THREADS);
    assign dec       = r_rdata - pts_pkg::TICKS_W'(1);
    assign sw        = !r_cur_valid || (hr != r_cur_prio);

    always_comb begin
        hr = '0;
        for (int i = 0; i < pts_pkg::NUM_THREADS; i++) begin
            if (r_ready[i]) begin
                hr = pts_pkg::PRIO_W'(i + 1);
            end
        end
    end

    always_comb begin
        n_ready   = r_ready;
        n_delayed = r_delayed;
        n_sched   = r_sched;
        n_err     = r_err;
        mem_we    = 1'b0;
        mem_waddr = cur_idx;
        mem_wdata = r_ticks;
        if (i_cmd.capture) begin
            n_sched = 1'b0;
            n_err   = 1'b0;
        end
        if (i_cmd.exec) begin
            case (r_op)
                pts_pkg::OP_START: begin
                    if (start_ok) begin
                        n_ready[start_idx] = 1'b1;
                    end
                end
                pts_pkg::OP_DELAY: begin
                    if (delay_bad) begin
                        n_err = 1'b1;
                    end else begin
                        n_ready[cur_idx]   = 1'b0;
                        n_delayed[cur_idx] = 1'b1;
                        mem_we             = 1'b1;
                        n_sched            = 1'b1;
                    end
                end
                pts_pkg::OP_SCHED: begin
                    n_sched = 1'b1;
                end
                default: begin
                    n_sched = r_sched;
                end
            endcase
        end
        if (i_cmd.tick_step && r_rd_vld && r_delayed[r_rd_idx]) begin
            mem_we    = 1'b1;
            mem_waddr = r_rd_idx;
            mem_wdata = dec;
            if (dec == '0) begin
                n_ready[r_rd_idx]   = 1'b1;
                n_delayed[r_rd_idx] = 1'b0;
            end
        end
    end

    // timeout memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.tick_step && walk_more) begin
            r_rdata <= r_mem[r_walk[pts_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= pts_pkg::t_opcode'(i_opcode);
            r_prio  <= i_thread_prio;
            r_ticks <= i_delay_ticks;
        end
        if (i_cmd.tick_step && walk_more) begin
            r_rd_idx <= r_walk[pts_pkg::IDX_W-1:0];
        end
        if (i_cmd.finish) begin
            r_out_prio   <= hr;
            r_out_switch <= r_sched && sw;
            r_out_error  <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready     <= '0;
            r_delayed   <= '0;
            r_cur_prio  <= '0;
            r_cur_valid <= 1'b0;
            r_sched     <= 1'b0;
            r_err       <= 1'b0;
            r_walk      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ready     <= n_ready;
            r_delayed   <= n_delayed;
            r_sched     <= n_sched;
            r_err       <= n_err;
            r_out_valid <= i_cmd.finish;
            if (i_cmd.exec && (r_op == pts_pkg::OP_TICK)) begin
                r_walk   <= '0;
                r_rd_vld <= 1'b0;
            end else if (i_cmd.tick_step) begin
                if (walk_more) begin
                    r_walk   <= r_walk + pts_pkg::WALK_W'(1);
                    r_rd_vld <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
            end
            if (i_cmd.finish && r_sched) begin
                r_cur_prio  <= hr;
                r_cur_valid <= 1'b1;
            end
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.walk_done = !walk_more && !r_rd_vld;

    assign o_next_prio      = r_out_prio;
    assign o_switch_request = r_out_switch;
    assign o_error          = r_out_error;
    assign o_valid          = r_out_valid;

endmodule

>>> src/priority_task_scheduler_with_delays.sv
// Top level of the bitmap priority scheduler with timed delays.
// One command word is taken when start is high and busy is low; its single
// result word appears on the o_ ports for exactly one cycle with o_valid high,
// and the receiver cannot stall it. Start, delay and schedule pass through the
// EXEC and RESULT states, and the result is registered after RESULT. A tick's
// length is set by the walk in the TICK state over the timeout memory, one entry
// read per cycle through its single read port with the update overlapped. busy
// drops in the cycle the result is shown, so the next command can be taken then.
module priority_task_scheduler_with_delays (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pts_pkg::OP_W-1:0]     i_opcode,
    input  logic [pts_pkg::PRIO_W-1:0]   i_thread_prio,
    input  logic [pts_pkg::TICKS_W-1:0]  i_delay_ticks,
    output logic [pts_pkg::PRIO_W-1:0]   o_next_prio,
    output logic                         o_switch_request,
    output logic                         o_error,
    output logic                         o_valid
);

    pts_pkg::t_dp_cmd  cmd;
    pts_pkg::t_dp_stat stat;

    pts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pts_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_opcode         (i_opcode),
        .i_thread_prio    (i_thread_prio),
        .i_delay_ticks    (i_delay_ticks),
        .o_next_prio      (o_next_prio),
        .o_switch_request (o_switch_request),
        .o_error          (o_error),
        .o_valid          (o_valid)
    );

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted word did not raise busy");

    a_error_no_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> !o_switch_request)
        else $error("rejected delay raised a switch request");

endmodule
